// ===== rtl/core/sis_pkg.sv =====
package sis_pkg;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CMD_W  = 2;

  localparam logic [VAL_W-1:0] UPPER_BOUND_RESET = {VAL_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_ELEMENT   = 3'd4,
    STAT_EMPTY     = 3'd5,
    STAT_CLEARED   = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } sis_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  element;
    logic [CNT_W-1:0]  count;
    logic              last;
  } sis_out_t;

  // Broadcast control shared by every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             rot;
    logic [VAL_W-1:0] value;
  } sis_ctrl_t;

endpackage

// ===== rtl/core/sis_cell.sv =====
module sis_cell
  import sis_pkg::*;
(
  input  logic             clk_i,
  input  sis_ctrl_t        ctrl_i,
  input  logic             valid_i,
  input  logic             prev_lt_i,
  input  logic [VAL_W-1:0] prev_val_i,
  input  logic [VAL_W-1:0] next_val_i,
  input  logic [VAL_W-1:0] head_val_i,
  input  logic             wrap_i,
  output logic             lt_o,
  output logic             eq_o,
  output logic [VAL_W-1:0] val_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;

  assign lt_o  = valid_i && (val_q < ctrl_i.value);
  assign eq_o  = valid_i && (val_q == ctrl_i.value);
  assign val_o = val_q;

  // A cell whose entry is not below the new value either takes the new value
  // (when its lower neighbor is below it) or the entry of its lower neighbor.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && !lt_o) begin
      val_d = prev_lt_i ? ctrl_i.value : prev_val_i;
    end else if (ctrl_i.rot) begin
      val_d = wrap_i ? head_val_i : next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/core/sorted_integer_set.sv =====
// Sorted integer set built as a chain of compare-and-shift cells.
// Commands arrive on item_i and are taken at a clock edge where start_i is
// high and busy_o is low. An insert compares the value against every cell at
// once; the cell at the insertion point takes the value and cells above it
// take their lower neighbor's entry, so an insert leaves busy_o low and the
// next command may follow in the very next cycle. Its single result is
// registered and shows on result_o the cycle after, marked by result_valid_o.
// A report rotates the chain down by one place per cycle, with the head cell
// driving the result, so it streams count entries, one per cycle, starting
// once the state register has entered the report state and the head entry is
// registered. busy_o is high during the rotation, which runs ahead of the
// results by the result register, so the next command can be taken at the
// edge accepting the last entry; by then the chain is back in original order.
// A report of an empty set, a clear and an insert each give one result.
// Each result is valid for exactly one cycle; the receiver cannot stall it.
// Reset empties the set and restores upper_bound to its maximum; the stored
// entries themselves are not cleared, since only slots below the count are
// ever read. upper_bound is written over the APB port at byte address 0.
module sorted_integer_set
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  sis_in_t     item_i,
  output logic        result_valid_o,
  output sis_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Configuration register.
  logic [VAL_W-1:0] ub_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, ub_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ub_q <= UPPER_BOUND_RESET;
    end else if (cfg_wr) begin
      ub_q <= pwdata[VAL_W-1:0];
    end
  end

  // Control state.
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rvalid_q, rvalid_d;
  sis_out_t        res_q, res_d;

  sis_ctrl_t       ctrl;
  logic            accept;

  // Chain wiring.
  logic [CAPACITY-1:0]  lt;
  logic [CAPACITY-1:0]  eq;
  logic [VAL_W-1:0]     cell_val [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_lt;
    logic [VAL_W-1:0] prev_val;
    logic [VAL_W-1:0] next_val;

    if (i == 0) begin : g_first
      // The head cell has no lower neighbor, so on a shift it takes the new value.
      assign prev_lt  = 1'b1;
      assign prev_val = ctrl.value;
    end else begin : g_rest
      assign prev_lt  = lt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_val = cell_val[0];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    sis_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (CntW'(i) < count_q),
      .prev_lt_i  (prev_lt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .head_val_i (cell_val[0]),
      .wrap_i     (CntW'(i) == (count_q - CntW'(1))),
      .lt_o       (lt[i]),
      .eq_o       (eq[i]),
      .val_o      (cell_val[i])
    );
  end

  assign busy_o = (state_q == S_REPORT);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    rvalid_d      = 1'b0;
    res_d         = res_q;
    ctrl.ins      = 1'b0;
    ctrl.rot      = 1'b0;
    ctrl.value    = item_i.value;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            CMD_INSERT: begin
              rvalid_d      = 1'b1;
              res_d.element = '0;
              res_d.last    = 1'b1;
              if (item_i.value >= ub_q) begin
                res_d.status = STAT_RANGE;
              end else if (|eq) begin
                res_d.status = STAT_DUPLICATE;
              end else if (count_q == CntW'(CAPACITY)) begin
                res_d.status = STAT_FULL;
              end else begin
                res_d.status = STAT_INSERTED;
                ctrl.ins     = 1'b1;
                count_d      = count_q + CntW'(1);
              end
              res_d.count = CNT_W'(count_d);
            end
            CMD_REPORT: begin
              if (count_q == '0) begin
                rvalid_d      = 1'b1;
                res_d.status  = STAT_EMPTY;
                res_d.element = '0;
                res_d.count   = '0;
                res_d.last    = 1'b1;
              end else begin
                state_d = S_REPORT;
                idx_d   = '0;
              end
            end
            CMD_CLEAR: begin
              count_d       = '0;
              rvalid_d      = 1'b1;
              res_d.status  = STAT_CLEARED;
              res_d.element = '0;
              res_d.count   = '0;
              res_d.last    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPORT: begin
        // The head cell holds the next entry in order; rotate the chain.
        rvalid_d      = 1'b1;
        res_d.status  = STAT_ELEMENT;
        res_d.element = cell_val[0];
        res_d.count   = CNT_W'(count_q);
        res_d.last    = (idx_q == (count_q - CntW'(1)));
        ctrl.rot      = 1'b1;
        idx_d         = idx_q + CntW'(1);
        if (res_d.last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

endmodule
